// ===== rtl/slbc_pkg.sv =====
// Shared types and constants for the status LED breathing controller.
// No dependencies; imported by every module of the block.
package slbc_pkg;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned LVL_W      = 8;

    localparam logic [LVL_W-1:0] RAMP_INTERVAL_RST  = 8'd5;
    localparam logic [LVL_W-1:0] PWM_PERIOD_RST     = 8'd42;
    localparam logic [LVL_W-1:0] BLINK_ON_TICKS_RST = 8'd100;
    localparam logic [LVL_W-1:0] BLINK_PERIOD_RST   = 8'd200;
    localparam logic [LVL_W-1:0] LVL_MAX            = 8'd255;

    typedef enum logic [1:0] {
        REG_RAMP_INTERVAL  = 2'd0,
        REG_PWM_PERIOD     = 2'd1,
        REG_BLINK_ON_TICKS = 2'd2,
        REG_BLINK_PERIOD   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [LVL_W-1:0] blink_period;
        logic [LVL_W-1:0] blink_on_ticks;
        logic [LVL_W-1:0] pwm_period;
        logic [LVL_W-1:0] ramp_interval;
    } t_cfg;

    // charging lands in bit 0 when cast from tdata
    typedef struct packed {
        logic suction_mode;
        logic motor_running;
        logic heating;
        logic working;
        logic low_battery;
        logic charge_full;
        logic charging;
    } t_flags;

    typedef struct packed {
        logic red_on;
        logic white_on;
    } t_leds;

    function automatic logic [LVL_W-1:0] sat_inc(input logic [LVL_W-1:0] v);
        return (v == LVL_MAX) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/slbc_apb_regs.sv =====
// APB register file holding the four timing registers.
// Depends on slbc_pkg.
module slbc_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slbc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [slbc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [slbc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output slbc_pkg::t_cfg                  o_cfg
);
    import slbc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_interval  <= RAMP_INTERVAL_RST;
            r_cfg.pwm_period     <= PWM_PERIOD_RST;
            r_cfg.blink_on_ticks <= BLINK_ON_TICKS_RST;
            r_cfg.blink_period   <= BLINK_PERIOD_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RAMP_INTERVAL:  r_cfg.ramp_interval  <= pwdata[LVL_W-1:0];
                REG_PWM_PERIOD:     r_cfg.pwm_period     <= pwdata[LVL_W-1:0];
                REG_BLINK_ON_TICKS: r_cfg.blink_on_ticks <= pwdata[LVL_W-1:0];
                REG_BLINK_PERIOD:   r_cfg.blink_period   <= pwdata[LVL_W-1:0];
                default:            r_cfg.ramp_interval  <= r_cfg.ramp_interval;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_RAMP_INTERVAL:  prdata[LVL_W-1:0] = r_cfg.ramp_interval;
            REG_PWM_PERIOD:     prdata[LVL_W-1:0] = r_cfg.pwm_period;
            REG_BLINK_ON_TICKS: prdata[LVL_W-1:0] = r_cfg.blink_on_ticks;
            REG_BLINK_PERIOD:   prdata[LVL_W-1:0] = r_cfg.blink_period;
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== rtl/slbc_step.sv =====
// Tick counters, breathing ramp and LED state; one tick per enabled cycle.
// Depends on slbc_pkg.
module slbc_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  slbc_pkg::t_flags i_flags,
    input  slbc_pkg::t_cfg  i_cfg,
    output slbc_pkg::t_leds o_leds
);
    import slbc_pkg::*;

    logic [LVL_W-1:0] r_pwm_phase, n_pwm_phase;
    logic [LVL_W-1:0] r_ramp_ticks, n_ramp_ticks;
    logic [LVL_W-1:0] r_blink_ticks, n_blink_ticks;
    logic [LVL_W-1:0] r_duty_level, n_duty_level;
    logic             r_ramping_down, n_ramping_down;
    logic             r_white, n_white;
    logic             r_red, n_red;

    always_comb begin
        n_pwm_phase    = sat_inc(r_pwm_phase);
        n_ramp_ticks   = sat_inc(r_ramp_ticks);
        n_blink_ticks  = sat_inc(r_blink_ticks);
        n_duty_level   = r_duty_level;
        n_ramping_down = r_ramping_down;
        n_white        = r_white;
        n_red          = r_red;

        if (i_flags.charging) begin
            n_red = 1'b0;
            if (i_flags.charge_full) begin
                n_white        = 1'b1;
                n_pwm_phase    = '0;
                n_duty_level   = '0;
                n_ramp_ticks   = '0;
                n_ramping_down = 1'b0;
            end else begin
                if (n_ramp_ticks >= i_cfg.ramp_interval) begin
                    n_ramp_ticks = '0;
                    if (r_ramping_down) begin
                        if (r_duty_level != '0) begin
                            n_duty_level = r_duty_level - 1'b1;
                        end else begin
                            n_ramping_down = 1'b0;
                        end
                    end else begin
                        n_duty_level = sat_inc(r_duty_level);
                        if (n_duty_level > i_cfg.pwm_period) begin
                            n_ramping_down = 1'b1;
                        end
                    end
                end
                priority if (n_pwm_phase < n_duty_level) begin
                    n_white = 1'b1;
                end else if (n_pwm_phase < i_cfg.pwm_period) begin
                    n_white = 1'b0;
                end else begin
                    n_pwm_phase = '0;
                end
            end
        end else begin
            n_duty_level   = '0;
            n_ramping_down = 1'b0;
            if (i_flags.low_battery) begin
                if (i_flags.working) begin
                    priority if (n_blink_ticks < i_cfg.blink_on_ticks) begin
                        n_white = 1'b1;
                    end else if (n_blink_ticks < i_cfg.blink_period) begin
                        n_white = 1'b0;
                    end else begin
                        n_blink_ticks = '0;
                    end
                    n_red = i_flags.heating;
                end
            end else if (i_flags.working) begin
                n_white = i_flags.motor_running || i_flags.suction_mode;
                n_red   = i_flags.heating;
            end else begin
                n_white = 1'b0;
                n_red   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_phase    <= '0;
            r_ramp_ticks   <= '0;
            r_blink_ticks  <= '0;
            r_duty_level   <= '0;
            r_ramping_down <= 1'b0;
            r_white        <= 1'b0;
            r_red          <= 1'b0;
        end else if (i_en) begin
            r_pwm_phase    <= n_pwm_phase;
            r_ramp_ticks   <= n_ramp_ticks;
            r_blink_ticks  <= n_blink_ticks;
            r_duty_level   <= n_duty_level;
            r_ramping_down <= n_ramping_down;
            r_white        <= n_white;
            r_red          <= n_red;
        end
    end

    assign o_leds.white_on = n_white;
    assign o_leds.red_on   = n_red;

endmodule

// ===== rtl/status_led_breathing_controller.sv =====
// Status LED controller: one tick beat in, one LED beat out, one beat per cycle
// while the output is not stalled, through the tick register and then the result
// register. Ready drops only while a result waits on a stalled output. Registers
// on APB: ramp_interval 0x0, pwm_period 0x4, blink_on_ticks 0x8, blink_period
// 0xC (low byte used). Depends on slbc_pkg, slbc_apb_regs and slbc_step.
module status_led_breathing_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [0] charging [1] charge_full [2] low_battery [3] working [4] heating
    // [5] motor_running [6] suction_mode [7] zero
    input  logic [7:0]                      s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] white_on [1] red_on [7:2] zero
    output logic [7:0]                      m_axis_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slbc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [slbc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [slbc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import slbc_pkg::*;

    t_cfg   w_cfg;
    t_flags r_in_flags;
    logic   r_in_valid;
    t_leds  w_leds;
    t_leds  r_out_leds;
    logic   r_out_valid;
    logic   w_advance;

    slbc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_flags <= t_flags'(s_axis_tdata[6:0]);
        end
    end

    slbc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_advance),
        .i_flags (r_in_flags),
        .i_cfg   (w_cfg),
        .o_leds  (w_leds)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_leds <= w_leds;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_leds};

endmodule

// ===== rtl/slbc_checker.sv =====
// Port-level checks for the status LED controller, bound to the top level.
// Depends on slbc_pkg and status_led_breathing_controller.
module slbc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [7:0]                      m_axis_tdata,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [slbc_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [slbc_pkg::CFG_DATA_W-1:0] pwdata,
    input logic [slbc_pkg::CFG_DATA_W-1:0] prdata
);
    import slbc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed while stalled");

    a_reg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=>
            ((psel && !pwrite && (paddr[3:2] == $past(paddr[3:2])))
                -> (prdata[LVL_W-1:0] == $past(pwdata[LVL_W-1:0]))))
        else $error("register readback mismatch");

endmodule

bind status_led_breathing_controller slbc_checker u_slbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
